// File: rtl/shift_array_list_macros.svh
// Assertion helpers used by the list sequencer (sal_ctrl).
`ifndef SHIFT_ARRAY_LIST_MACROS_SVH
`define SHIFT_ARRAY_LIST_MACROS_SVH

// Same-cycle implication, inactive while reset is asserted.
`define SAL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("shift_array_list: same-cycle check failed");

// Next-cycle implication, inactive while reset is asserted.
`define SAL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("shift_array_list: next-cycle check failed");

`endif

// File: rtl/sal_pkg.sv
`timescale 1ns / 1ps

package sal_pkg;

    // Default list capacity
    localparam int SAL_DEPTH = 64;

    // Word width of one entry
    localparam int SAL_WORD_W = 32;

    // Operation codes carried on the input tuser
    typedef enum logic [2:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_BACK  = 3'd1,
        OP_FIND      = 3'd2,
        OP_GET       = 3'd3,
        OP_REM_FRONT = 3'd4
    } sal_op_t;

    // Result status codes
    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_FULL  = 2'd1,
        STS_EMPTY = 2'd2,
        STS_MISS  = 2'd3
    } sal_status_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } sal_state_t;

    // Action applied by every cell of the chain at once
    typedef enum logic [2:0] {
        CA_HOLD,
        CA_SHIFT_UP,
        CA_SHIFT_DOWN,
        CA_APPEND,
        CA_ROTATE
    } sal_cell_act_t;

    // Command broadcast from the sequencer to the cell chain
    typedef struct packed {
        sal_cell_act_t         act;
        logic [SAL_WORD_W-1:0] data;
    } sal_cell_ctl_t;

endpackage

// File: rtl/sal_cell.sv
`timescale 1ns / 1ps

module sal_cell
    import sal_pkg::*;
#(
    parameter int POS   = 0,
    parameter int CNT_W = 7
)
(
    input  logic                  clk,
    input  sal_cell_ctl_t         ctl,
    input  logic [CNT_W-1:0]      count,
    input  logic [SAL_WORD_W-1:0] prev_entry,
    input  logic [SAL_WORD_W-1:0] next_entry,
    input  logic [SAL_WORD_W-1:0] head_entry,
    output logic [SAL_WORD_W-1:0] entry
);

    localparam logic [CNT_W-1:0] POS_C  = CNT_W'(POS);
    localparam logic [CNT_W-1:0] POS_P1 = CNT_W'(POS + 1);

    logic [SAL_WORD_W-1:0] entry_reg;
    logic [SAL_WORD_W-1:0] entry_next;

    // Pick the new entry from the neighbors, the broadcast word or the head
    always_comb
    begin
        entry_next = entry_reg;
        unique case (ctl.act)
            CA_HOLD:
            begin
                entry_next = entry_reg;
            end
            CA_SHIFT_UP:
            begin
                entry_next = prev_entry;
            end
            CA_SHIFT_DOWN:
            begin
                entry_next = next_entry;
            end
            CA_APPEND:
            begin
                if (count == POS_C)
                begin
                    entry_next = ctl.data;
                end
            end
            CA_ROTATE:
            begin
                // Used cells move one place toward the head, the tail takes the head
                if (count > POS_P1)
                begin
                    entry_next = next_entry;
                end
                else if (count == POS_P1)
                begin
                    entry_next = head_entry;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    // Hold the entry
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// File: rtl/sal_ctrl.sv
`timescale 1ns / 1ps
`include "shift_array_list_macros.svh"

module sal_ctrl
    import sal_pkg::*;
#(
    parameter  int DEPTH = SAL_DEPTH,
    localparam int IDX_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Operation side
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [2:0]            in_op,
    input  logic [SAL_WORD_W-1:0] in_value,
    input  logic [IDX_W-1:0]      in_index,
    // Cell chain
    input  logic [SAL_WORD_W-1:0] head_entry,
    output sal_cell_ctl_t         cell_ctl,
    output logic [CNT_W-1:0]      count,
    // Result side
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [SAL_WORD_W-1:0] out_read_value,
    output logic [IDX_W-1:0]      out_position,
    output logic                  out_found,
    output sal_status_t           out_status,
    output logic [CNT_W-1:0]      out_count
);

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

    sal_state_t state_reg, state_next;

    logic [CNT_W-1:0]      count_reg, count_next;
    logic [IDX_W-1:0]      step_reg, step_next;
    logic [SAL_WORD_W-1:0] key_reg, key_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic                  find_reg, find_next;
    logic                  hit_reg, hit_next;
    logic [IDX_W-1:0]      pos_reg, pos_next;
    logic [SAL_WORD_W-1:0] rd_reg, rd_next;

    logic                  out_valid_reg, out_valid_next;
    logic [SAL_WORD_W-1:0] out_read_value_reg, out_read_value_next;
    logic [IDX_W-1:0]      out_position_reg, out_position_next;
    logic                  out_found_reg, out_found_next;
    sal_status_t           out_status_reg, out_status_next;
    logic [CNT_W-1:0]      out_count_reg, out_count_next;

    logic    out_free;
    logic    accept;
    logic    scan_start;
    logic    last_step;
    sal_op_t op;

    assign op        = sal_op_t'(in_op);
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept    = in_valid && in_ready;
    assign last_step = (CNT_W'(step_reg) + ONE_C) == count_reg;

    // Find and get with something to look at walk the chain
    always_comb
    begin
        scan_start = 1'b0;
        if (accept)
        begin
            if (op == OP_FIND)
            begin
                scan_start = (count_reg != '0);
            end
            else if (op == OP_GET)
            begin
                scan_start = (CNT_W'(in_index) < count_reg);
            end
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (scan_start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (last_step)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Cell commands, scan bookkeeping and result loading
    always_comb
    begin
        cell_ctl.act        = CA_HOLD;
        cell_ctl.data       = in_value;
        count_next          = count_reg;
        step_next           = step_reg;
        key_next            = key_reg;
        idx_next            = idx_reg;
        find_next           = find_reg;
        hit_next            = hit_reg;
        pos_next            = pos_reg;
        rd_next             = rd_reg;
        out_valid_next      = out_valid_reg && !out_ready;
        out_read_value_next = out_read_value_reg;
        out_position_next   = out_position_reg;
        out_found_next      = out_found_reg;
        out_status_next     = out_status_reg;
        out_count_next      = out_count_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    out_read_value_next = '0;
                    out_position_next   = '0;
                    out_found_next      = 1'b0;
                    out_status_next     = STS_OK;
                    out_valid_next      = !scan_start;
                    unique case (op) inside
                        OP_INS_FRONT:
                        begin
                            if (count_reg == DEPTH_C)
                            begin
                                out_status_next = STS_FULL;
                            end
                            else
                            begin
                                cell_ctl.act = CA_SHIFT_UP;
                                count_next   = count_reg + ONE_C;
                            end
                        end
                        OP_INS_BACK:
                        begin
                            if (count_reg == DEPTH_C)
                            begin
                                out_status_next = STS_FULL;
                            end
                            else
                            begin
                                cell_ctl.act = CA_APPEND;
                                count_next   = count_reg + ONE_C;
                            end
                        end
                        OP_REM_FRONT:
                        begin
                            if (count_reg == '0)
                            begin
                                out_status_next = STS_EMPTY;
                            end
                            else
                            begin
                                cell_ctl.act = CA_SHIFT_DOWN;
                                count_next   = count_reg - ONE_C;
                            end
                        end
                        OP_FIND, OP_GET:
                        begin
                            out_status_next = STS_MISS;
                            key_next        = in_value;
                            idx_next        = in_index;
                            find_next       = (op == OP_FIND);
                            hit_next        = 1'b0;
                            pos_next        = '0;
                            rd_next         = '0;
                            step_next       = '0;
                        end
                        default:
                        begin
                            out_status_next = STS_MISS;
                        end
                    endcase
                    out_count_next = count_next;
                end
            end
            ST_SCAN:
            begin
                // Compare the word passing the head, then advance the ring
                cell_ctl.act = CA_ROTATE;
                step_next    = step_reg + IDX_W'(1);
                if (find_reg)
                begin
                    if (!hit_reg && (head_entry == key_reg))
                    begin
                        hit_next = 1'b1;
                        pos_next = step_reg;
                    end
                end
                else if (step_reg == idx_reg)
                begin
                    hit_next = 1'b1;
                    rd_next  = head_entry;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next      = 1'b1;
                    out_read_value_next = rd_reg;
                    out_position_next   = pos_reg;
                    out_found_next      = hit_reg;
                    out_status_next     = hit_reg ? STS_OK : STS_MISS;
                    out_count_next      = count_reg;
                end
            end
            default:
            begin
                cell_ctl.act = CA_HOLD;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Scan and result payload
    always_ff @(posedge clk)
    begin
        step_reg           <= step_next;
        key_reg            <= key_next;
        idx_reg            <= idx_next;
        find_reg           <= find_next;
        hit_reg            <= hit_next;
        pos_reg            <= pos_next;
        rd_reg             <= rd_next;
        out_read_value_reg <= out_read_value_next;
        out_position_reg   <= out_position_next;
        out_found_reg      <= out_found_next;
        out_status_reg     <= out_status_next;
        out_count_reg      <= out_count_next;
    end

    assign count          = count_reg;
    assign out_valid      = out_valid_reg;
    assign out_read_value = out_read_value_reg;
    assign out_position   = out_position_reg;
    assign out_found      = out_found_reg;
    assign out_status     = out_status_reg;
    assign out_count      = out_count_reg;

    // Checks
    `SAL_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_reg <= DEPTH_C)
    `SAL_ASSERT_IMPL(a_step_in_use, clk, rst_n, state_reg == ST_SCAN, CNT_W'(step_reg) < count_reg)
    `SAL_ASSERT_NEXT(a_scan_keeps_count, clk, rst_n, state_reg == ST_SCAN, $stable(count_reg))
    `SAL_ASSERT_IMPL(a_found_is_ok, clk, rst_n, out_valid_reg && out_found_reg, out_status_reg == STS_OK)

endmodule

// File: rtl/shift_array_list.sv
`timescale 1ns / 1ps

// Bounded ordered list of DEPTH 32-bit words kept in a chain of cells, entry 0 at the head.
// The operation code travels on s_tuser; s_tdata carries the word and the get position.
// Insert-front, insert-back, remove-front, an insert into a full list, a remove from an
// empty list, a get out of range, a find on an empty list and an unknown code need no
// scan, and the next transfer can follow in the next cycle once the result register
// is free. Find and get rotate the used part of the chain past the head cell, one entry a
// cycle, and restore the original order when done; a new transfer is taken only after
// the scan and finish states are through. The result, with found and status on m_tuser,
// sits in an output register until the downstream side takes it. Entries that were
// never written hold no defined value; reset empties the list at once.
module shift_array_list
    import sal_pkg::*;
#(
    parameter  int DEPTH  = SAL_DEPTH,
    localparam int IDX_W  = $clog2(DEPTH),
    localparam int CNT_W  = $clog2(DEPTH + 1),
    localparam int S_DW   = ((SAL_WORD_W + IDX_W + 7) / 8) * 8,
    localparam int M_DW   = ((SAL_WORD_W + IDX_W + CNT_W + 7) / 8) * 8
)
(
    input  logic            clk,
    input  logic            rst_n,
    // Operations
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [S_DW-1:0] s_tdata,   // value, index, zero fill
    input  logic [2:0]      s_tuser,   // op
    // Results
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [M_DW-1:0] m_tdata,   // read_value, position, count, zero fill
    output logic [2:0]      m_tuser    // found, status
);

    logic [SAL_WORD_W-1:0] entry_arr [DEPTH];
    sal_cell_ctl_t         cell_ctl;
    logic [CNT_W-1:0]      count;
    logic [SAL_WORD_W-1:0] out_read_value;
    logic [IDX_W-1:0]      out_position;
    logic                  out_found;
    sal_status_t           out_status;
    logic [CNT_W-1:0]      out_count;

    // Sequencer
    sal_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .in_op          (s_tuser),
        .in_value       (s_tdata[SAL_WORD_W-1:0]),
        .in_index       (s_tdata[SAL_WORD_W +: IDX_W]),
        .head_entry     (entry_arr[0]),
        .cell_ctl       (cell_ctl),
        .count          (count),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_read_value (out_read_value),
        .out_position   (out_position),
        .out_found      (out_found),
        .out_status     (out_status),
        .out_count      (out_count)
    );

    // Cell chain; the head takes the broadcast word, the tail takes zero from beyond
    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        logic [SAL_WORD_W-1:0] prev_entry;
        logic [SAL_WORD_W-1:0] next_entry;

        if (k == 0)
        begin : g_head
            assign prev_entry = cell_ctl.data;
        end
        else
        begin : g_body
            assign prev_entry = entry_arr[k-1];
        end

        if (k == DEPTH - 1)
        begin : g_tail
            assign next_entry = '0;
        end
        else
        begin : g_inner
            assign next_entry = entry_arr[k+1];
        end

        sal_cell #(
            .POS   (k),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk        (clk),
            .ctl        (cell_ctl),
            .count      (count),
            .prev_entry (prev_entry),
            .next_entry (next_entry),
            .head_entry (entry_arr[0]),
            .entry      (entry_arr[k])
        );
    end

    // Pack the result
    assign m_tdata = M_DW'({out_count, out_position, out_read_value});
    assign m_tuser = {out_status, out_found};

endmodule
